@@ rtl/sffc_pkg.sv @@
package sffc_pkg;

  // Fixed formats
  localparam int SAMPLE_BITS   = 24;
  localparam int COEF_BITS     = 24;
  localparam int LEVEL_BITS    = 25;
  localparam int THR_BITS      = 15;
  localparam int OGAIN_BITS    = 16;
  localparam int GR_BITS       = 14;
  localparam int GR_MAX        = 15360;
  localparam int LEVEL_FLOOR   = 17;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;
  localparam int QDEPTH        = 4;
  localparam int QPTR_BITS     = $clog2(QDEPTH);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_RATIO     = 3'd1,
    CFG_SOFT_KNEE = 3'd2,
    CFG_ATTACK    = 3'd3,
    CFG_RELEASE   = 3'd4,
    CFG_OUT_GAIN  = 3'd5
  } sffc_cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic signed [SAMPLE_BITS-1:0] sidechain_left;
    logic signed [SAMPLE_BITS-1:0] sidechain_right;
    logic                          sidechain_present;
  } sffc_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [GR_BITS-1:0]            gain_reduction;
  } sffc_out_t;

  typedef struct packed {
    logic signed [THR_BITS-1:0] thresh;
    logic [2:0]                 ratio_select;
    logic                       soft_knee_on;
    logic [COEF_BITS-1:0]       attack_coef;
    logic [COEF_BITS-1:0]       release_coef;
    logic [OGAIN_BITS-1:0]      output_gain;
  } sffc_cfg_t;

  // Classified frame handed from front to back
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic [LEVEL_BITS-1:0]         level;
  } sffc_item_t;

  typedef enum logic [4:0] {
    BK_IDLE, BK_LOG, BK_DB, BK_DIFF, BK_KNEE1, BK_KNEE2, BK_KNEE3,
    BK_EXP, BK_GAIN, BK_SHIFT, BK_REL1, BK_REL2, BK_ATK1, BK_ATK2,
    BK_FINL1, BK_FINL2, BK_FINR1, BK_FINR2, BK_WRITE
  } sffc_bk_state_e;

  // Slope 1 - 1/ratio in Q16; codes 6 and 7 both act as 20 to one
  function automatic logic [15:0] slope_of(input logic [2:0] sel);
    logic [15:0] s;
    case (sel)
      3'd0:    s = 16'd0;
      3'd1:    s = 16'd32768;
      3'd2:    s = 16'd49152;
      3'd3:    s = 16'd54613;
      3'd4:    s = 16'd57344;
      3'd5:    s = 16'd60075;
      default: s = 16'd62259;
    endcase
    return s;
  endfunction

  // 2^(-2^-(k+1)) in Q0.24
  function automatic logic [23:0] pow_coef(input logic [3:0] k);
    logic [23:0] c;
    case (k)
      4'd0:    c = 24'd11863283;
      4'd1:    c = 24'd14107901;
      4'd2:    c = 24'd15384775;
      4'd3:    c = 24'd16065917;
      4'd4:    c = 24'd16417715;
      4'd5:    c = 24'd16596492;
      4'd6:    c = 24'd16686609;
      4'd7:    c = 24'd16731852;
      4'd8:    c = 24'd16754518;
      4'd9:    c = 24'd16765863;
      4'd10:   c = 24'd16771539;
      default: c = 24'd16774377;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/sffc_front.sv @@
module sffc_front import sffc_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  sffc_in_t   in_data_i,
  input  logic       q_full_i,
  output logic       push_o,
  output sffc_item_t item_o
);

  logic signed [SAMPLE_BITS-1:0] det_a, det_b;
  logic [SAMPLE_BITS-1:0]        mag_a, mag_b, mag_max;
  logic [LEVEL_BITS-1:0]         lvl;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Detector source select and peak magnitude
  always_comb begin
    det_a   = in_data_i.sidechain_present ? in_data_i.sidechain_left  : in_data_i.left_sample;
    det_b   = in_data_i.sidechain_present ? in_data_i.sidechain_right : in_data_i.right_sample;
    mag_a   = det_a[SAMPLE_BITS-1] ? SAMPLE_BITS'(-det_a) : SAMPLE_BITS'(det_a);
    mag_b   = det_b[SAMPLE_BITS-1] ? SAMPLE_BITS'(-det_b) : SAMPLE_BITS'(det_b);
    mag_max = (mag_a > mag_b) ? mag_a : mag_b;
    lvl     = {mag_max, 1'b0};
    if (lvl < LEVEL_BITS'(LEVEL_FLOOR)) begin
      lvl = LEVEL_BITS'(LEVEL_FLOOR);
    end
  end

  assign item_o.left  = in_data_i.left_sample;
  assign item_o.right = in_data_i.right_sample;
  assign item_o.level = lvl;

endmodule

@@ rtl/sffc_queue.sv @@
module sffc_queue import sffc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  sffc_item_t item_i,
  output logic       full_o,
  output logic       valid_o,
  output sffc_item_t item_o,
  input  logic       pop_i
);

  sffc_item_t           mem_q [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_BITS:0]   count_q;

  assign full_o  = (count_q == (QPTR_BITS+1)'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

@@ rtl/sffc_back.sv @@
module sffc_back import sffc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sffc_cfg_t  cfg_i,
  input  logic       q_valid_i,
  input  sffc_item_t q_item_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output sffc_out_t  out_data_o
);

  localparam logic [LEVEL_BITS-1:0] ONE = LEVEL_BITS'(1) << COEF_BITS;

  sffc_bk_state_e state_q, state_d;

  // Control and smoother state
  logic [3:0]            cnt_q;
  logic [LEVEL_BITS-1:0] sl_q, hold_q;
  logic                  out_valid_q;

  // Per-item payload
  sffc_item_t                    item_q;
  logic [30:0]                   m_q;
  logic [15:0]                   frac_q;
  logic [4:0]                    pos_q;
  logic signed [17:0]            db_q;
  logic signed [18:0]            diff_q;
  logic [23:0]                   sq_q;
  logic [15:0]                   z_q;
  logic [GR_BITS-1:0]            gr_q;
  logic [15:0]                   e_q;
  logic [LEVEL_BITS-1:0]         g_q;
  logic                          atk_path_q;
  logic signed [65:0]            acc_q;
  logic signed [LEVEL_BITS-1:0]  t_q;
  logic signed [SAMPLE_BITS-1:0] yl_q;
  logic signed [SAMPLE_BITS-1:0] yr_q;
  sffc_out_t                     out_q;

  // Shared multiplier
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  assign prod = 66'(ma) * 66'(mb);

  logic [LEVEL_BITS-1:0] v_lvl;
  logic [4:0]            pos_d;
  logic [30:0]           m_d;
  logic signed [22:0]    l_s;
  logic signed [6:0]     p_exp;
  logic [11:0]           tk;
  logic                  knee_in, knee_low;
  logic [15:0]           slope;
  logic [LEVEL_BITS-1:0] omc_atk, omc_rel;
  logic signed [65:0]    db_full, lin_full, w_full, e_full, r24, mix_full, y_full;
  logic [31:0]           sqm;
  logic [GR_BITS-1:0]    lin_gr;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic                  out_load;

  // Helpers around the multiplier
  always_comb begin
    v_lvl = (sl_q < LEVEL_BITS'(LEVEL_FLOOR)) ? LEVEL_BITS'(LEVEL_FLOOR) : sl_q;
    pos_d = '0;
    for (int i = 0; i < LEVEL_BITS; i++) begin
      if (v_lvl[i]) pos_d = 5'(i);
    end
    m_d      = 31'({6'd0, v_lvl} << (5'd30 - pos_d));
    p_exp    = $signed({2'b00, pos_q}) - 7'sd24;
    l_s      = {p_exp, frac_q};
    tk       = 12'(diff_q + 19'sd1920);
    knee_low = (diff_q < -19'sd1920);
    knee_in  = !knee_low && (diff_q <= 19'sd1920);
    slope    = slope_of(cfg_i.ratio_select);
    omc_atk  = ONE - {1'b0, cfg_i.attack_coef};
    omc_rel  = ONE - {1'b0, cfg_i.release_coef};
    sqm      = prod[61:30];
    db_full  = (prod + 66'sd8388608) >>> 24;
    lin_full = (prod + 66'sd32768) >>> 16;
    w_full   = prod + 66'sd251658240;
    e_full   = (prod + 66'sd524288) >>> 20;
    r24      = (prod + 66'sd8388608) >>> 24;
    mix_full = (acc_q + prod + 66'sd8388608) >>> 24;
    y_full   = (prod + 66'sd2048) >>> 12;
    lin_gr   = (lin_full > 66'sd15360) ? GR_BITS'(GR_MAX) : lin_full[GR_BITS-1:0];
    if (y_full > 66'sd8388607)       y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    else if (y_full < -66'sd8388608) y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    else                             y_sat = y_full[SAMPLE_BITS-1:0];
  end

  // Multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      BK_LOG: begin
        ma = $signed({2'b00, m_q});
        mb = $signed({2'b00, m_q});
      end
      BK_DB: begin
        ma = 33'(l_s);
        mb = 33'sd394566;
      end
      BK_KNEE1: begin
        if (cfg_i.soft_knee_on && knee_in) begin
          ma = $signed({21'd0, tk});
          mb = $signed({21'd0, tk});
        end else begin
          ma = 33'(diff_q);
          mb = $signed({17'd0, slope});
        end
      end
      BK_KNEE2: begin
        ma = $signed({9'd0, sq_q});
        mb = $signed({17'd0, slope});
      end
      BK_KNEE3: begin
        ma = $signed({17'd0, z_q});
        mb = 33'sd34953;
      end
      BK_EXP: begin
        ma = $signed({19'd0, gr_q});
        mb = 33'sd2786635;
      end
      BK_GAIN: begin
        ma = $signed({8'd0, g_q});
        mb = $signed({9'd0, pow_coef(cnt_q)});
      end
      BK_REL1: begin
        ma = $signed({9'd0, cfg_i.release_coef});
        mb = $signed({8'd0, hold_q});
      end
      BK_REL2: begin
        ma = $signed({8'd0, omc_rel});
        mb = $signed({8'd0, item_q.level});
      end
      BK_ATK1: begin
        ma = $signed({9'd0, cfg_i.attack_coef});
        mb = $signed({8'd0, sl_q});
      end
      BK_ATK2: begin
        ma = $signed({8'd0, omc_atk});
        mb = $signed({8'd0, (atk_path_q ? item_q.level : hold_q)});
      end
      BK_FINL1: begin
        ma = 33'(item_q.left);
        mb = $signed({8'd0, g_q});
      end
      BK_FINR1: begin
        ma = 33'(item_q.right);
        mb = $signed({8'd0, g_q});
      end
      BK_FINL2, BK_FINR2: begin
        ma = 33'(t_q);
        mb = $signed({17'd0, cfg_i.output_gain});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          state_d = BK_LOG;
        end
      end
      BK_LOG:   if (cnt_q == 4'd15) state_d = BK_DB;
      BK_DB:    state_d = BK_DIFF;
      BK_DIFF:  state_d = BK_KNEE1;
      BK_KNEE1: state_d = (cfg_i.soft_knee_on && knee_in) ? BK_KNEE2 : BK_EXP;
      BK_KNEE2: state_d = BK_KNEE3;
      BK_KNEE3: state_d = BK_EXP;
      BK_EXP:   state_d = BK_GAIN;
      BK_GAIN:  if (cnt_q == 4'd11) state_d = BK_SHIFT;
      BK_SHIFT: state_d = (item_q.level > sl_q) ? BK_ATK1 : BK_REL1;
      BK_REL1:  state_d = BK_REL2;
      BK_REL2:  state_d = BK_ATK1;
      BK_ATK1:  state_d = BK_ATK2;
      BK_ATK2:  state_d = BK_FINL1;
      BK_FINL1: state_d = BK_FINL2;
      BK_FINL2: state_d = BK_FINR1;
      BK_FINR1: state_d = BK_FINR2;
      BK_FINR2: state_d = BK_WRITE;
      BK_WRITE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default:  state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BK_IDLE;
    else         state_q <= state_d;
  end

  // Step counter, smoother state, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      sl_q        <= '0;
      hold_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == BK_LOG || state_q == BK_GAIN) begin
        cnt_q <= (state_d == state_q) ? cnt_q + 1'b1 : '0;
      end
      if (state_q == BK_REL2) begin
        hold_q <= (item_q.level > mix_full[LEVEL_BITS-1:0]) ? item_q.level
                                                            : mix_full[LEVEL_BITS-1:0];
      end
      if (state_q == BK_ATK2) sl_q <= mix_full[LEVEL_BITS-1:0];
      if (out_load)                       out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        item_q <= q_item_i;
        pos_q  <= pos_d;
        m_q    <= m_d;
        frac_q <= '0;
      end
      BK_LOG: begin
        m_q    <= sqm[31] ? sqm[31:1] : sqm[30:0];
        frac_q <= {frac_q[14:0], sqm[31]};
      end
      BK_DB:   db_q   <= db_full[17:0];
      BK_DIFF: diff_q <= 19'(db_q) - 19'(cfg_i.thresh);
      BK_KNEE1: begin
        if (cfg_i.soft_knee_on && knee_low)     gr_q <= '0;
        else if (cfg_i.soft_knee_on && knee_in) sq_q <= prod[23:0];
        else if (cfg_i.soft_knee_on || !diff_q[18]) gr_q <= lin_gr;
        else                                    gr_q <= '0;
      end
      BK_KNEE2: z_q  <= w_full[40:25];
      BK_KNEE3: gr_q <= prod[GR_BITS+18:19];
      BK_EXP: begin
        e_q <= e_full[15:0];
        g_q <= ONE;
      end
      BK_GAIN: if (e_q[4'd11 - cnt_q]) g_q <= r24[LEVEL_BITS-1:0];
      BK_SHIFT: begin
        g_q        <= g_q >> e_q[15:12];
        atk_path_q <= (item_q.level > sl_q);
      end
      BK_REL1, BK_ATK1: acc_q <= prod;
      BK_FINL1, BK_FINR1: t_q <= r24[LEVEL_BITS-1:0];
      BK_FINL2: yl_q <= y_sat;
      BK_FINR2: yr_q <= y_sat;
      // the output register changes only when the previous item has left
      BK_WRITE: begin
        if (out_load) begin
          out_q.left_out       <= yl_q;
          out_q.right_out      <= yr_q;
          out_q.gain_reduction <= gr_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/stereo_feedforward_compressor.sv @@
// Stereo feed-forward compressor with hard or soft knee.
// Input channel (in_valid_i / in_ready_o / in_data_i): one stereo frame plus an
// optional sidechain pair per item. The front stage picks the detector peak and
// drops the frame into a 4-entry queue; in_ready_o is low only when it is full.
// Output channel (out_valid_o / out_ready_i / out_data_o): compressed pair and
// the gain reduction applied to that frame, held in an output register.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i): always
// ready; write only while the block is idle.
// The back sequencer takes one frame at a time from the queue and steps it
// through in order on its single shared multiplier: 16 log2 squaring steps,
// 12 gain product steps, 2 or 4 smoother steps and 4 output scaling steps;
// the soft knee region adds the KNEE2 and KNEE3 steps.
// Reset: smoother level and release hold clear to zero, registers take their
// defaults (unity output gain), queue and output register empty.
// Receiver stall: the finished frame waits in the output register, the back
// sequencer holds in its last step, and the queue keeps taking frames until full.
module stereo_feedforward_compressor import sffc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  sffc_in_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output sffc_out_t                out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  sffc_cfg_t  cfg_q;
  logic       push, q_full, q_valid, pop;
  sffc_item_t push_item, q_item;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thresh       <= '0;
      cfg_q.ratio_select <= '0;
      cfg_q.soft_knee_on <= 1'b0;
      cfg_q.attack_coef  <= '0;
      cfg_q.release_coef <= '0;
      cfg_q.output_gain  <= OGAIN_BITS'(4096);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_THRESHOLD: cfg_q.thresh       <= $signed(cfg_data_i[THR_BITS-1:0]);
        CFG_RATIO:     cfg_q.ratio_select <= cfg_data_i[2:0];
        CFG_SOFT_KNEE: cfg_q.soft_knee_on <= cfg_data_i[0];
        CFG_ATTACK:    cfg_q.attack_coef  <= cfg_data_i[COEF_BITS-1:0];
        CFG_RELEASE:   cfg_q.release_coef <= cfg_data_i[COEF_BITS-1:0];
        CFG_OUT_GAIN:  cfg_q.output_gain  <= cfg_data_i[OGAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  sffc_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (push_item)
  );

  sffc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (pop)
  );

  sffc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/sffc_checker.sv @@
module sffc_checker import sffc_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input sffc_in_t                 in_data_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input sffc_out_t                out_data_o,
  input logic                     cfg_valid_i,
  input logic                     cfg_ready_o,
  input logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Reduction stays within its clamp
  a_gr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.gain_reduction <= GR_MAX)
    else $error("gain reduction out of range");

  // Nothing is offered while in reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

  // Register writes are always taken
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind stereo_feedforward_compressor sffc_checker u_sffc_checker (.*);

@@ tb/sv/sffc_checker.sv @@
`timescale 1ns / 1ps
module sffc_tb_checker import sffc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  sffc_in_t                 in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  sffc_out_t                out_data_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output int                       errors_o,
  output int                       pending_o
);

  // Own copy of the compressor state and registers
  logic [LEVEL_BITS-1:0]      env_level;
  logic [LEVEL_BITS-1:0]      hold_level;
  logic signed [THR_BITS-1:0] thr_q;
  logic [2:0]                 ratio_q;
  logic                       knee_q;
  logic [COEF_BITS-1:0]       atk_q;
  logic [COEF_BITS-1:0]       rel_q;
  logic [OGAIN_BITS-1:0]      ogain_q;
  sffc_out_t                  frame_q[$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  // Level (Q1.24) to 1/256 dB via bitwise log2
  function automatic longint db_of_level(input longint lv);
    longint unsigned v, m;
    longint          p, frac, l;
    v = (lv < LEVEL_FLOOR) ? LEVEL_FLOOR : lv;
    p = 0;
    frac = 0;
    while (p < 31 && (v >> (p + 1)) != 0) p++;
    m = v << (30 - p);
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    l = (p - 24) * 65536 + frac;
    return (l * 394566 + (64'sd1 <<< 23)) >>> 24;
  endfunction

  // Knee curve: reduction in 1/256 dB, capped
  function automatic longint knee_reduction(input longint lvl);
    longint s, diff, gr, t;
    s = slope_of(ratio_q);
    diff = lvl - longint'(thr_q);
    gr = 0;
    if (knee_q) begin
      if (2 * diff < -3840) gr = 0;
      else if (2 * diff <= 3840) begin
        t = diff + 1920;
        gr = (t * t * s + 503316480 / 2) / 503316480;
      end else gr = (diff * s + 32768) >>> 16;
    end else if (diff >= 0) gr = (diff * s + 32768) >>> 16;
    return (gr > GR_MAX) ? GR_MAX : gr;
  endfunction

  // Linear gain Q1.24 from reduction
  function automatic longint lin_gain(input longint gr);
    longint unsigned e, n, g;
    e = (gr * 2786635 + (1 << 19)) >> 20;
    n = e >> 12;
    g = 64'd1 << 24;
    for (int k = 0; k < 12; k++)
      if ((e >> (11 - k)) & 1) g = (g * pow_coef(k[3:0]) + (64'd1 << 23)) >> 24;
    return (n >= 25) ? 0 : longint'(g >> n);
  endfunction

  function automatic longint blend(input longint c, input longint a, input longint b);
    return (c * a + ((64'sd1 <<< COEF_BITS) - c) * b + (64'sd1 <<< (COEF_BITS - 1)))
           >>> COEF_BITS;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] scale_sat(input longint x, input longint g);
    longint t, y;
    t = (x * g + (64'sd1 <<< 23)) >>> 24;
    y = (t * longint'(ogain_q) + 2048) >>> 12;
    if (y > 8388607) y = 8388607;
    if (y < -8388608) y = -8388608;
    return y[SAMPLE_BITS-1:0];
  endfunction

  // One frame: result from held level, then smoother update
  function automatic sffc_out_t compress_frame(input sffc_in_t d);
    longint    a, b, pk, lv, gr, g, h;
    sffc_out_t r;
    if (d.sidechain_present) begin
      a = longint'(d.sidechain_left);
      b = longint'(d.sidechain_right);
    end else begin
      a = longint'(d.left_sample);
      b = longint'(d.right_sample);
    end
    if (a < 0) a = -a;
    if (b < 0) b = -b;
    pk = (a > b) ? a : b;
    lv = pk << 1;
    if (lv < LEVEL_FLOOR) lv = LEVEL_FLOOR;
    gr = knee_reduction(db_of_level(longint'(env_level)));
    g = lin_gain(gr);
    if (lv > longint'(env_level)) begin
      env_level = LEVEL_BITS'(blend(atk_q, env_level, lv));
    end else begin
      h = blend(rel_q, hold_level, lv);
      hold_level = LEVEL_BITS'((lv > h) ? lv : h);
      env_level = LEVEL_BITS'(blend(atk_q, env_level, hold_level));
    end
    r.left_out = scale_sat(longint'(d.left_sample), g);
    r.right_out = scale_sat(longint'(d.right_sample), g);
    r.gain_reduction = gr[GR_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sffc_out_t want;
    if (!rst_ni) begin
      env_level = '0;
      hold_level = '0;
      thr_q = '0;
      ratio_q = '0;
      knee_q = 1'b0;
      atk_q = '0;
      rel_q = '0;
      ogain_q = 16'd4096;
      frame_q.delete();
      errors_o = 0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_THRESHOLD: thr_q = cfg_data_i[THR_BITS-1:0];
          CFG_RATIO:     ratio_q = cfg_data_i[2:0];
          CFG_SOFT_KNEE: knee_q = cfg_data_i[0];
          CFG_ATTACK:    atk_q = cfg_data_i;
          CFG_RELEASE:   rel_q = cfg_data_i;
          CFG_OUT_GAIN:  ogain_q = cfg_data_i[OGAIN_BITS-1:0];
          default: ;
        endcase
      end
      // compare results against oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (frame_q.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          want = frame_q.pop_front();
          if (out_data_i.left_out !== want.left_out)
            report_mismatch("left_out", out_data_i.left_out, want.left_out);
          if (out_data_i.right_out !== want.right_out)
            report_mismatch("right_out", out_data_i.right_out, want.right_out);
          if (out_data_i.gain_reduction !== want.gain_reduction)
            report_mismatch("gain_reduction", out_data_i.gain_reduction,
                            want.gain_reduction);
        end
      end
      if (in_valid_i && in_ready_i) frame_q.push_back(compress_frame(in_data_i));
    end
    pending_o = frame_q.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import sffc_pkg::*;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  sffc_in_t                 in_data_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  sffc_out_t                out_data_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  int                       errors;
  int                       pending;

  int tx_idle = 32;
  int rx_idle = 74;
  bit stall_req = 1'b0;
  bit stall_seen = 1'b0;
  int stall_left = 0;
  int sent = 0;
  int waited;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  stereo_feedforward_compressor uut (.*);

  sffc_tb_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  // Receiver: random ready, with one long hold-off on request
  always @(posedge clk_i) begin
    if (stall_req && !stall_seen) begin
      stall_seen <= 1'b1;
      stall_left <= 400;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_frame(input sffc_in_t d);
    in_data_i <= d;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Wait on the clock first so the last accepted item is counted as pending
  task automatic drain_all();
    in_valid_i <= 1'b0;
    waited = 0;
    @(posedge clk_i);
    while (pending != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(input sffc_cfg_idx_e idx, input int val);
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DATA_BITS'(val);
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_settings(input int thr, input int ratio, input int knee,
                               input int atk, input int rel, input int og);
    drain_all();
    write_reg(CFG_THRESHOLD, thr & 32'h7FFF);
    write_reg(CFG_RATIO, ratio);
    write_reg(CFG_SOFT_KNEE, knee);
    write_reg(CFG_ATTACK, atk);
    write_reg(CFG_RELEASE, rel);
    write_reg(CFG_OUT_GAIN, og);
  endtask

  // Random sample spread over the whole dB range
  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    logic [SAMPLE_BITS-1:0] v;
    if ($urandom_range(0, 9) == 0) v = SAMPLE_BITS'($urandom);
    else begin
      v = SAMPLE_BITS'($urandom >> (8 + $urandom_range(0, 23)));
      if ($urandom_range(0, 1)) v = -v;
    end
    return v;
  endfunction

  function automatic sffc_in_t make_frame(input int l, input int r, input int sl,
                                          input int sr, input int sp);
    sffc_in_t f;
    f.left_sample = SAMPLE_BITS'(l);
    f.right_sample = SAMPLE_BITS'(r);
    f.sidechain_left = SAMPLE_BITS'(sl);
    f.sidechain_right = SAMPLE_BITS'(sr);
    f.sidechain_present = sp[0];
    return f;
  endfunction

  initial begin
    int thr_set[6]   = '{-4608, -16384, 16383, -2560, -7680, -1280};
    int ratio_set[6] = '{3, 7, 6, 1, 4, 5};
    int knee_set[6]  = '{1, 0, 1, 1, 0, 1};
    int atk_set[6]   = '{16000000, 0, 16777215, 8000000, 12000000, 16500000};
    int rel_set[6]   = '{16700000, 0, 16777215, 16770000, 0, 16600000};
    int og_set[6]    = '{4096, 65535, 0, 8192, 2048, 5000};
    int burst;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset registers (1:1 ratio, zero coefficients), field extremes
    send_frame(make_frame(0, 0, 0, 0, 0));
    send_frame(make_frame(8388607, -8388608, 0, 0, 0));
    send_frame(make_frame(-8388608, 8388607, 0, 0, 1));
    send_frame(make_frame(100, -100, 8388607, -8388608, 1));
    send_frame(make_frame(1, -1, 0, 0, 0));
    load_settings(-4608, 7, 0, 0, 0, 65535);
    send_frame(make_frame(8388607, 8388607, 0, 0, 0));
    send_frame(make_frame(-8388608, -8388608, 0, 0, 0));
    send_frame(make_frame(4000000, -4000000, 8388607, 0, 1));
    send_frame(make_frame(-5, 5, 0, 0, 1));
    send_frame(make_frame(0, 0, 0, 0, 0));
    load_settings(16383, 6, 1, 16777215, 16777215, 0);
    send_frame(make_frame(8388607, -8388608, 0, 0, 0));
    send_frame(make_frame(-1, 1, -8388608, 8388607, 1));
    send_frame(make_frame(0, 0, 0, 0, 0));
    load_settings(-16384, 2, 1, 1, 1, 4095);
    send_frame(make_frame(8388607, 0, 0, 0, 0));
    send_frame(make_frame(0, -8388608, 0, 0, 0));
    send_frame(make_frame(2000000, 2000000, 3, 3, 1));
    send_frame(make_frame(-8388608, 8388607, 0, 0, 0));

    // Random phases, each under its own settings
    for (int ph = 0; ph < 6; ph++) begin
      load_settings(thr_set[ph], ratio_set[ph], knee_set[ph], atk_set[ph],
                    rel_set[ph], og_set[ph]);
      for (int i = 0; i < 255; i++) begin
        if (sent < 540) begin
          tx_idle = 32;
          rx_idle = 74;
        end else if (sent < 1060) begin
          tx_idle = 74;
          rx_idle = 32;
        end else begin
          tx_idle = 0;
          rx_idle = 0;
        end
        // long receiver hold-off with the sender pushing
        if (ph == 4 && i == 20) begin
          tx_idle = 0;
          stall_req <= 1'b1;
        end
        // sender pauses until every result is in
        if (ph == 3 && i == 100) drain_all();
        burst = $urandom_range(0, 3);
        if (burst == 0)
          send_frame(make_frame(rand_sample(), rand_sample(), rand_sample(),
                                rand_sample(), $urandom_range(0, 1)));
        else if (burst == 1)
          send_frame(make_frame($urandom, $urandom, $urandom, $urandom, $urandom));
        else begin
          // loud then quiet runs exercise attack and release
          if (i % 32 < 8)
            send_frame(make_frame(rand_sample() | 24'h400000, rand_sample(),
                                  rand_sample(), rand_sample(), 0));
          else
            send_frame(make_frame(rand_sample() >>> 6, rand_sample() >>> 6,
                                  rand_sample(), rand_sample(), $urandom_range(0, 1)));
        end
      end
    end

    drain_all();
    $display("covered %0d frames over 10 register settings, hard and soft knee,", sent);
    $display("all ratios, sidechain on and off, with stalls on both sides");
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/sffc_pkg.sv
rtl/sffc_front.sv
rtl/sffc_queue.sv
rtl/sffc_back.sv
rtl/stereo_feedforward_compressor.sv
rtl/sffc_checker.sv
tb/sv/sffc_checker.sv
tb/sv/testbench.sv
